// ===== rtl/blpb_pkg.sv =====
// constants and register codes for the normalized blinn-phong evaluator
// no dependencies; used by blinn_phong_brdf_eval
package blpb_pkg;

	localparam int EXP_BITS   = 12;
	localparam int FRAC_BITS  = 14;
	localparam int IN_W       = 16;
	localparam int OUT_W      = 24;
	localparam int EXPREG_W   = 12;
	localparam int ALB_W      = 16;
	localparam int CFG_W      = 16;

	// half vector and its length
	localparam int H_W        = IN_W + 1;
	localparam int SQ_W       = 2 * H_W - 1;
	localparam int L_W        = SQ_W + 1;
	localparam int SQRT_SHIFT = 28;
	localparam int RAD_W      = L_W + SQRT_SHIFT;
	localparam int ROOT_W     = RAD_W / 2;

	// normalized cosine and its powers
	localparam int C_W        = FRAC_BITS + 1;
	localparam int C_SHIFT    = FRAC_BITS + 14;
	localparam int CNUM_W     = H_W + C_SHIFT;

	// clamped normal components and denominator
	localparam int Y_W        = IN_W - 1;
	localparam int D_W        = 2 * Y_W;

	// lobe normalization (k+2)/(2pi)
	localparam int INV_W      = 30;
	localparam logic [INV_W-1:0] INV_TWO_PI = INV_W'(683565276);
	localparam int KP_W       = EXP_BITS + 1;
	localparam int G_W        = EXP_BITS + 14;
	localparam int M_W        = G_W;
	localparam int N_W        = M_W + C_W;
	localparam int REFL_SHIFT = FRAC_BITS - 6;
	localparam int NUM_W      = N_W + REFL_SHIFT;
	localparam int RD_W       = D_W + OUT_W - 1;
	localparam int DENS_SHIFT = FRAC_BITS + 4;
	localparam int DP_W       = G_W + C_W;

	localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

	typedef enum logic [1:0] {
		CFG_EXPONENT = 2'd0,
		CFG_ALB_RED  = 2'd1,
		CFG_ALB_GRN  = 2'd2,
		CFG_ALB_BLU  = 2'd3
	} cfg_idx_t;

endpackage

// ===== rtl/blinn_phong_brdf_eval.sv =====
// normalized blinn-phong reflectance and lobe density, fully pipelined
// depends on blpb_pkg for widths, constants and register codes

// One item enters per clock while in_stall is low; the pipeline moves as one,
// so a result held on the output (out_valid high, out_stall high) freezes every
// stage and raises in_stall, and nothing is lost or repeated. The pipeline
// depth is set by the half-vector length square root (one root bit per stage,
// 31 stages), the cosine divider (15 stages), the square-and-multiply power
// chain (two stages per exponent bit, 24 stages) and the reflectance
// dividers (24 stages, the three colors side by side). Items
// with a non-positive normal component on either direction, or with a zero
// half vector, come out with all fields zero and valid_res low. Registers are
// written through cfg_we / cfg_idx / cfg_data and must only change while the
// pipeline is empty; the lobe factors g and then m are registered from them.
module blinn_phong_brdf_eval (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_we,
	input  logic [1:0]                          cfg_idx,
	input  logic [blpb_pkg::CFG_W-1:0]          cfg_data,
	// input items
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [blpb_pkg::IN_W-1:0]    out_x,
	input  logic signed [blpb_pkg::IN_W-1:0]    out_y,
	input  logic signed [blpb_pkg::IN_W-1:0]    out_z,
	input  logic signed [blpb_pkg::IN_W-1:0]    in_x,
	input  logic signed [blpb_pkg::IN_W-1:0]    in_y,
	input  logic signed [blpb_pkg::IN_W-1:0]    in_z,
	// result items
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [blpb_pkg::OUT_W-1:0]          refl_red,
	output logic [blpb_pkg::OUT_W-1:0]          refl_green,
	output logic [blpb_pkg::OUT_W-1:0]          refl_blue,
	output logic [blpb_pkg::OUT_W-1:0]          density,
	output logic                                valid_res
);

	localparam int EB   = blpb_pkg::EXP_BITS;
	localparam int FB   = blpb_pkg::FRAC_BITS;
	localparam int H_W  = blpb_pkg::H_W;
	localparam int SQ_W = blpb_pkg::SQ_W;
	localparam int L_W  = blpb_pkg::L_W;
	localparam int RAD_W  = blpb_pkg::RAD_W;
	localparam int ROOT_W = blpb_pkg::ROOT_W;
	localparam int C_W    = blpb_pkg::C_W;
	localparam int CNUM_W = blpb_pkg::CNUM_W;
	localparam int Y_W    = blpb_pkg::Y_W;
	localparam int D_W    = blpb_pkg::D_W;
	localparam int G_W    = blpb_pkg::G_W;
	localparam int M_W    = blpb_pkg::M_W;
	localparam int N_W    = blpb_pkg::N_W;
	localparam int NUM_W  = blpb_pkg::NUM_W;
	localparam int RD_W   = blpb_pkg::RD_W;
	localparam int OUT_W  = blpb_pkg::OUT_W;
	localparam int PW_N   = 2 * EB;
	localparam logic [C_W-1:0] C_ONE = C_W'(1) << FB;

	// whole pipeline advances unless a result is held at the output
	logic adv;
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// ---------------- configuration registers and lobe factors ----------------
	logic [blpb_pkg::EXPREG_W-1:0] exponent_q;
	logic [blpb_pkg::ALB_W-1:0]    alb_q [0:2];
	logic [G_W-1:0]                g_q;
	logic [M_W-1:0]                m_q [0:2];
	logic [EB-1:0]                 k;

	assign k = exponent_q[EB-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exponent_q <= blpb_pkg::EXPREG_W'(1);
			alb_q[0]   <= {blpb_pkg::ALB_W{1'b1}};
			alb_q[1]   <= {blpb_pkg::ALB_W{1'b1}};
			alb_q[2]   <= {blpb_pkg::ALB_W{1'b1}};
		end else if (cfg_we) begin
			unique case (blpb_pkg::cfg_idx_t'(cfg_idx))
				blpb_pkg::CFG_EXPONENT: exponent_q <= cfg_data[blpb_pkg::EXPREG_W-1:0];
				blpb_pkg::CFG_ALB_RED:  alb_q[0]   <= cfg_data[blpb_pkg::ALB_W-1:0];
				blpb_pkg::CFG_ALB_GRN:  alb_q[1]   <= cfg_data[blpb_pkg::ALB_W-1:0];
				blpb_pkg::CFG_ALB_BLU:  alb_q[2]   <= cfg_data[blpb_pkg::ALB_W-1:0];
				default: ;
			endcase
		end
	end

	// g = (k+2)/(2pi) in q.16, then m = albedo * g per color
	logic [blpb_pkg::KP_W+blpb_pkg::INV_W-1:0] g_prod;
	assign g_prod = (blpb_pkg::KP_W+blpb_pkg::INV_W)'(
		({1'b0, k} + blpb_pkg::KP_W'(2)) * blpb_pkg::INV_TWO_PI);

	always_ff @(posedge clk) begin
		g_q <= g_prod[G_W+15:16];
	end

	for (genvar ch = 0; ch < 3; ch++) begin : g_mfac
		logic [blpb_pkg::ALB_W+G_W-1:0] m_prod;
		assign m_prod = alb_q[ch] * g_q;
		always_ff @(posedge clk) begin
			m_q[ch] <= m_prod[M_W+15:16];
		end
	end

	// ---------------- stage 1: half vector and special cases ----------------
	logic signed [H_W-1:0] hx, hy, hz;
	assign hx = H_W'(out_x) + H_W'(in_x);
	assign hy = H_W'(out_y) + H_W'(in_y);
	assign hz = H_W'(out_z) + H_W'(in_z);

	logic                  v_s1, bad_s1;
	logic signed [H_W-1:0] hx_s1, hy_s1, hz_s1;
	logic [Y_W-1:0]        iy_s1, oy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hx_s1  <= hx;
			hy_s1  <= hy;
			hz_s1  <= hz;
			iy_s1  <= in_y[Y_W-1:0];
			oy_s1  <= out_y[Y_W-1:0];
			bad_s1 <= (out_y <= 0) || (in_y <= 0) || (hx == 0 && hy == 0 && hz == 0);
		end
	end

	// ---------------- stage 2: squares and denominator ----------------
	logic signed [2*H_W-1:0] sqx, sqy, sqz;
	assign sqx = hx_s1 * hx_s1;
	assign sqy = hy_s1 * hy_s1;
	assign sqz = hz_s1 * hz_s1;

	logic            v_s2, bad_s2;
	logic [SQ_W-1:0] sqx_s2, sqy_s2, sqz_s2;
	logic [H_W-1:0]  hyp_s2;
	logic [D_W-1:0]  d_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s2 <= sqx[SQ_W-1:0];
			sqy_s2 <= sqy[SQ_W-1:0];
			sqz_s2 <= sqz[SQ_W-1:0];
			hyp_s2 <= (hy_s1 > 0) ? hy_s1 : '0;
			d_s2   <= iy_s1 * oy_s1;
			bad_s2 <= bad_s1;
		end
	end

	// ---------------- square root of L * 2^28, one bit per stage ----------------
	logic              rt_v_s   [0:ROOT_W];
	logic              rt_bad_s [0:ROOT_W];
	logic [RAD_W-1:0]  rt_rem_s [0:ROOT_W];
	logic [ROOT_W-1:0] rt_q_s   [0:ROOT_W];
	logic [H_W-1:0]    rt_hy_s  [0:ROOT_W];
	logic [D_W-1:0]    rt_d_s   [0:ROOT_W];

	logic [L_W-1:0] len2;
	assign len2 = L_W'(sqx_s2) + L_W'(sqy_s2) + L_W'(sqz_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rt_v_s[0] <= 1'b0;
		else if (adv) rt_v_s[0] <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rt_rem_s[0] <= {len2, {blpb_pkg::SQRT_SHIFT{1'b0}}};
			rt_q_s[0]   <= '0;
			rt_hy_s[0]  <= hyp_s2;
			rt_d_s[0]   <= d_s2;
			rt_bad_s[0] <= bad_s2;
		end
	end

	for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
		localparam int J = ROOT_W - 1 - i;
		logic [RAD_W:0] trial;
		logic           take;
		// (2q + 2^j) * 2^j, q holding the root bits found so far
		assign trial = ((RAD_W+1)'(rt_q_s[i]) << (J + 1)) + ((RAD_W+1)'(1) << (2 * J));
		assign take  = {1'b0, rt_rem_s[i]} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rt_v_s[i+1] <= 1'b0;
			else if (adv) rt_v_s[i+1] <= rt_v_s[i];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rt_rem_s[i+1] <= take ? rt_rem_s[i] - trial[RAD_W-1:0] : rt_rem_s[i];
				rt_q_s[i+1]   <= take ? rt_q_s[i] | (ROOT_W'(1) << J) : rt_q_s[i];
				rt_hy_s[i+1]  <= rt_hy_s[i];
				rt_d_s[i+1]   <= rt_d_s[i];
				rt_bad_s[i+1] <= rt_bad_s[i];
			end
		end
	end

	// ---------------- cosine c = hy * 2^(F+14) / r, one bit per stage ----------------
	logic              cd_v_s   [0:C_W-1];
	logic              cd_bad_s [0:C_W-1];
	logic [CNUM_W-1:0] cd_rem_s [0:C_W-1];
	logic [C_W-1:0]    cd_q_s   [0:C_W-1];
	logic [ROOT_W-1:0] cd_r_s   [0:C_W-1];
	logic [D_W-1:0]    cd_d_s   [0:C_W-1];

	for (genvar i = 0; i < C_W; i++) begin : g_cdiv
		localparam int J = C_W - 1 - i;
		logic              v_in, bad_in;
		logic [CNUM_W-1:0] rem_in;
		logic [C_W-1:0]    q_in;
		logic [ROOT_W-1:0] r_in;
		logic [D_W-1:0]    d_in;
		logic [CNUM_W-1:0] sub;
		logic              take;

		if (i == 0) begin : g_first
			assign v_in   = rt_v_s[ROOT_W];
			assign bad_in = rt_bad_s[ROOT_W];
			assign rem_in = {rt_hy_s[ROOT_W], {blpb_pkg::C_SHIFT{1'b0}}};
			assign q_in   = '0;
			assign r_in   = rt_q_s[ROOT_W];
			assign d_in   = rt_d_s[ROOT_W];
		end else begin : g_next
			assign v_in   = cd_v_s[i-1];
			assign bad_in = cd_bad_s[i-1];
			assign rem_in = cd_rem_s[i-1];
			assign q_in   = cd_q_s[i-1];
			assign r_in   = cd_r_s[i-1];
			assign d_in   = cd_d_s[i-1];
		end

		assign sub  = CNUM_W'(r_in) << J;
		assign take = rem_in >= sub;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) cd_v_s[i] <= 1'b0;
			else if (adv) cd_v_s[i] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				cd_rem_s[i] <= take ? rem_in - sub : rem_in;
				cd_q_s[i]   <= take ? q_in | (C_W'(1) << J) : q_in;
				cd_r_s[i]   <= r_in;
				cd_d_s[i]   <= d_in;
				cd_bad_s[i] <= bad_in;
			end
		end
	end

	// ---------------- c^k, square then conditional multiply per exponent bit ----------------
	logic           pw_v_s   [0:PW_N-1];
	logic           pw_bad_s [0:PW_N-1];
	logic [C_W-1:0] pw_p_s   [0:PW_N-1];
	logic [C_W-1:0] pw_c_s   [0:PW_N-1];
	logic [D_W-1:0] pw_d_s   [0:PW_N-1];

	for (genvar i = 0; i < PW_N; i++) begin : g_pow
		localparam int B = EB - 1 - i / 2;
		logic             v_in, bad_in;
		logic [C_W-1:0]   p_in, c_in;
		logic [D_W-1:0]   d_in;
		logic [2*C_W-1:0] prod;

		if (i == 0) begin : g_first
			assign v_in   = cd_v_s[C_W-1];
			assign bad_in = cd_bad_s[C_W-1];
			assign p_in   = C_ONE;
			assign c_in   = cd_q_s[C_W-1];
			assign d_in   = cd_d_s[C_W-1];
		end else begin : g_next
			assign v_in   = pw_v_s[i-1];
			assign bad_in = pw_bad_s[i-1];
			assign p_in   = pw_p_s[i-1];
			assign c_in   = pw_c_s[i-1];
			assign d_in   = pw_d_s[i-1];
		end

		// even stages square, odd stages multiply by c when the bit is set
		if (i % 2 == 0) begin : g_sq
			assign prod = p_in * p_in;
		end else begin : g_mul
			assign prod = k[B] ? p_in * c_in : {{(C_W - FB){1'b0}}, p_in, {FB{1'b0}}};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) pw_v_s[i] <= 1'b0;
			else if (adv) pw_v_s[i] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				pw_p_s[i]   <= prod[FB+C_W-1:FB];
				pw_c_s[i]   <= c_in;
				pw_d_s[i]   <= d_in;
				pw_bad_s[i] <= bad_in;
			end
		end
	end

	// ---------------- e1: c^(k+1) and color numerators ----------------
	logic [2*C_W-1:0] pk1_prod;
	assign pk1_prod = pw_p_s[PW_N-1] * pw_c_s[PW_N-1];

	logic           v_e1, bad_e1;
	logic [C_W-1:0] pk1_e1;
	logic [N_W-1:0] n_e1 [0:2];
	logic [D_W-1:0] d_e1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_e1 <= 1'b0;
		else if (adv) v_e1 <= pw_v_s[PW_N-1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pk1_e1 <= pk1_prod[FB+C_W-1:FB];
			d_e1   <= pw_d_s[PW_N-1];
			bad_e1 <= pw_bad_s[PW_N-1];
		end
	end

	for (genvar ch = 0; ch < 3; ch++) begin : g_num
		always_ff @(posedge clk) begin
			if (adv) n_e1[ch] <= m_q[ch] * pw_p_s[PW_N-1];
		end
	end

	// ---------------- e2: density, overflow check, dividends ----------------
	logic [blpb_pkg::DP_W-1:0] dens_prod;
	logic [blpb_pkg::DP_W-1:0] dens_full;
	assign dens_prod = g_q * pk1_e1;
	assign dens_full = dens_prod >> blpb_pkg::DENS_SHIFT;

	logic             v_e2, bad_e2;
	logic [OUT_W-1:0] dens_e2;
	logic [NUM_W-1:0] num_e2 [0:2];
	logic             ovf_e2 [0:2];
	logic [D_W-1:0]   d_e2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_e2 <= 1'b0;
		else if (adv) v_e2 <= v_e1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dens_e2 <= (dens_full > blpb_pkg::DP_W'(blpb_pkg::OUT_MAX))
				? blpb_pkg::OUT_MAX : dens_full[OUT_W-1:0];
			d_e2    <= d_e1;
			bad_e2  <= bad_e1;
		end
	end

	for (genvar ch = 0; ch < 3; ch++) begin : g_ovf
		// quotient of n * 2^(F-6) / d needs more than OUT_W bits
		logic [RD_W-1:0] lim;
		assign lim = RD_W'(d_e1) << (OUT_W - blpb_pkg::REFL_SHIFT);
		always_ff @(posedge clk) begin
			if (adv) begin
				num_e2[ch] <= {n_e1[ch], {blpb_pkg::REFL_SHIFT{1'b0}}};
				ovf_e2[ch] <= RD_W'(n_e1[ch]) >= lim;
			end
		end
	end

	// ---------------- reflectance dividers, one bit per stage ----------------
	logic             rd_v_s    [0:OUT_W-1];
	logic             rd_bad_s  [0:OUT_W-1];
	logic [D_W-1:0]   rd_d_s    [0:OUT_W-1];
	logic [OUT_W-1:0] rd_dens_s [0:OUT_W-1];
	logic [NUM_W-1:0] rd_rem_s  [0:OUT_W-1][0:2];
	logic [OUT_W-1:0] rd_q_s    [0:OUT_W-1][0:2];
	logic             rd_ovf_s  [0:OUT_W-1][0:2];

	for (genvar i = 0; i < OUT_W; i++) begin : g_rdiv
		localparam int J = OUT_W - 1 - i;
		logic             v_in, bad_in;
		logic [D_W-1:0]   d_in;
		logic [OUT_W-1:0] dens_in;
		logic [RD_W-1:0]  sub;

		if (i == 0) begin : g_first
			assign v_in    = v_e2;
			assign bad_in  = bad_e2;
			assign d_in    = d_e2;
			assign dens_in = dens_e2;
		end else begin : g_next
			assign v_in    = rd_v_s[i-1];
			assign bad_in  = rd_bad_s[i-1];
			assign d_in    = rd_d_s[i-1];
			assign dens_in = rd_dens_s[i-1];
		end

		assign sub = RD_W'(d_in) << J;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rd_v_s[i] <= 1'b0;
			else if (adv) rd_v_s[i] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rd_d_s[i]    <= d_in;
				rd_bad_s[i]  <= bad_in;
				rd_dens_s[i] <= dens_in;
			end
		end

		for (genvar ch = 0; ch < 3; ch++) begin : g_ch
			logic [NUM_W-1:0] rem_in;
			logic [OUT_W-1:0] q_in;
			logic             ovf_in;
			logic             take;

			if (i == 0) begin : g_first
				assign rem_in = num_e2[ch];
				assign q_in   = '0;
				assign ovf_in = ovf_e2[ch];
			end else begin : g_next
				assign rem_in = rd_rem_s[i-1][ch];
				assign q_in   = rd_q_s[i-1][ch];
				assign ovf_in = rd_ovf_s[i-1][ch];
			end

			assign take = RD_W'(rem_in) >= sub;

			always_ff @(posedge clk) begin
				if (adv) begin
					rd_rem_s[i][ch] <= take ? rem_in - sub[NUM_W-1:0] : rem_in;
					rd_q_s[i][ch]   <= take ? q_in | (OUT_W'(1) << J) : q_in;
					rd_ovf_s[i][ch] <= ovf_in;
				end
			end
		end
	end

	// ---------------- output register ----------------
	localparam int LR = OUT_W - 1;
	logic [OUT_W-1:0] refl_fin [0:2];

	for (genvar ch = 0; ch < 3; ch++) begin : g_fin
		// undefined items read zero, overflow saturates
		assign refl_fin[ch] = rd_bad_s[LR] ? '0
			: (rd_ovf_s[LR][ch] ? blpb_pkg::OUT_MAX : rd_q_s[LR][ch]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= rd_v_s[LR];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			refl_red   <= refl_fin[0];
			refl_green <= refl_fin[1];
			refl_blue  <= refl_fin[2];
			density    <= rd_bad_s[LR] ? '0 : rd_dens_s[LR];
			valid_res  <= !rd_bad_s[LR];
		end
	end

	// ---------------- checks ----------------
	// the cosine of a defined item never exceeds one
	a_cos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cd_v_s[C_W-1] && !cd_bad_s[C_W-1] |-> cd_q_s[C_W-1] <= C_ONE)
		else $error("cosine above one");

	// powers of a cosine at most one stay at most one
	a_pow_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pw_v_s[PW_N-1] && !pw_bad_s[PW_N-1] |-> pw_p_s[PW_N-1] <= C_ONE)
		else $error("power chain above one");

	// the red divider, when it did not overflow, ends with a remainder below the divisor
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_s[LR] && !rd_bad_s[LR] && !rd_ovf_s[LR][0]
		|-> RD_W'(rd_rem_s[LR][0]) < RD_W'(rd_d_s[LR]))
		else $error("red divider remainder not reduced");

	// an undefined result carries only zero fields
	a_zero_res: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res
		|-> refl_red == '0 && refl_green == '0 && refl_blue == '0 && density == '0)
		else $error("undefined result with nonzero fields");

endmodule
